>>> hw/rtl/sclc_pkg.sv
// Package for the serial command LED controller: request and result types,
// command word table, word codes and running-light modes.
// No dependencies.
package sclc_pkg;

    localparam int NUM_WORDS      = 8;
    localparam int MAX_WORD_CHARS = 8;
    localparam int PERIOD_W       = 16;

    localparam logic [7:0] TERM_CHAR = 8'h23;
    localparam logic [7:0] NUL_CHAR  = 8'h00;

    localparam logic [PERIOD_W-1:0] TICK_PERIOD_RESET = 16'd500;
    localparam logic [PERIOD_W-1:0] TICK_COUNT_RESET  = 16'd1;

    // Command kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Word codes as reported in matched_word
    localparam logic [3:0] WORD_NONE     = 4'd0;
    localparam logic [3:0] WORD_LED0_OFF = 4'd1;
    localparam logic [3:0] WORD_LED0_ON  = 4'd2;
    localparam logic [3:0] WORD_LED1_OFF = 4'd3;
    localparam logic [3:0] WORD_LED1_ON  = 4'd4;
    localparam logic [3:0] WORD_LEFT     = 4'd5;
    localparam logic [3:0] WORD_RIGHT    = 4'd6;
    localparam logic [3:0] WORD_FLASHING = 4'd7;
    localparam logic [3:0] WORD_TIME_OUT = 4'd8;

    // Word text, first character in the top byte, short words padded with NUL
    localparam logic [63:0] WORD_TEXT [NUM_WORDS] = '{
        64'("Led0:OFF"),
        {"Led0:ON", 8'h00},
        64'("Led1:OFF"),
        {"Led1:ON", 8'h00},
        {"left", 32'h0},
        {"right", 24'h0},
        64'("flashing"),
        64'("Time out")
    };

    localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
        4'd8, 4'd7, 4'd8, 4'd7, 4'd4, 4'd5, 4'd8, 4'd8
    };

    typedef enum logic [1:0] {
        MODE_PAUSE    = 2'd0,
        MODE_LEFT     = 2'd1,
        MODE_RIGHT    = 2'd2,
        MODE_FLASHING = 2'd3
    } light_mode_t;

    typedef struct packed {
        logic       command;
        logic [7:0] byte_value;
    } sclc_item_t;

    typedef struct packed {
        logic       led_zero;
        logic       led_one;
        logic [3:0] run_lights;
        logic [1:0] light_mode;
        logic [3:0] matched_word;
    } sclc_result_t;

    // Control from the pipeline to the lamp block
    typedef struct packed {
        logic       tick;
        logic       apply;
        logic [3:0] word;
    } sclc_lamp_ctl_t;

endpackage

>>> hw/rtl/sclc_if.sv
// Valid/ready channel interfaces for the serial command LED controller.
// Depends on sclc_pkg for the payload types.
interface sclc_in_if import sclc_pkg::*; ();
    logic       valid;
    logic       ready;
    sclc_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sclc_out_if import sclc_pkg::*; ();
    logic         valid;
    logic         ready;
    sclc_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/sclc_cmd_buf.sv
// Command character buffer with fill count, overflow mark and word matcher.
// Depends on sclc_pkg for the word table and codes.
module sclc_cmd_buf import sclc_pkg::*;
#(
    parameter int BUFFER_CHARS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       term,
    input  logic [7:0] byte_value,
    output logic [3:0] matched_word
);

    localparam int CW = $clog2(BUFFER_CHARS + 1);
    localparam int AW = $clog2(BUFFER_CHARS);

    logic [7:0]    chars_reg [BUFFER_CHARS];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          full;

    assign full = (count_reg == CW'(BUFFER_CHARS));

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            chars_reg[count_reg[AW-1:0]] <= byte_value;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (term)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (push)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Compare the held characters with every word at once; the length check
    // keeps unwritten entries out of any hit.
    always_comb
    begin
        logic hit;
        matched_word = WORD_NONE;
        for (int w = 0; w < NUM_WORDS; w++)
        begin
            hit = (count_reg == CW'(WORD_LEN[w]));
            for (int i = 0; i < MAX_WORD_CHARS; i++)
            begin
                if (i < int'(WORD_LEN[w]) &&
                    chars_reg[i] != WORD_TEXT[w][63 - 8*i -: 8])
                begin
                    hit = 1'b0;
                end
            end
            if (hit && !ovf_reg && matched_word == WORD_NONE)
            begin
                matched_word = 4'(w + 1);
            end
        end
    end

endmodule

>>> hw/rtl/sclc_lamps.sv
// LED and running-light state: tick counter, period register, mode and lamps.
// Depends on sclc_pkg for word codes, modes and the control struct.
module sclc_lamps import sclc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [PERIOD_W-1:0] cfg_wdata,
    input  sclc_lamp_ctl_t      ctl,
    output logic [5:0]          port_next,
    output light_mode_t         mode_next
);

    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] tick_count_reg;
    logic [PERIOD_W-1:0] tick_count_next;
    logic [PERIOD_W-1:0] tick_inc;
    logic [5:0]          port_reg;
    light_mode_t         mode_reg;
    logic [3:0]          lamps;
    logic [3:0]          lamps_step;
    logic                do_step;

    assign tick_inc = tick_count_reg + PERIOD_W'(1);
    assign do_step  = ctl.tick && (tick_inc >= period_reg);
    assign lamps    = port_reg[5:2];

    // One step of the running lights in the current mode
    always_comb
    begin
        lamps_step = lamps;
        unique case (mode_reg)
            MODE_LEFT:
            begin
                if (lamps == 4'h0 || lamps == 4'hF || lamps == 4'h8)
                    lamps_step = 4'h1;
                else if (lamps == 4'h1 || lamps == 4'h2 || lamps == 4'h4)
                    lamps_step = {lamps[2:0], 1'b0};
            end
            MODE_RIGHT:
            begin
                if (lamps == 4'h0 || lamps == 4'hF || lamps == 4'h1)
                    lamps_step = 4'h8;
                else if (lamps == 4'h2 || lamps == 4'h4 || lamps == 4'h8)
                    lamps_step = {1'b0, lamps[3:1]};
            end
            MODE_FLASHING: lamps_step = ~lamps;
            MODE_PAUSE:    lamps_step = lamps;
        endcase
    end

    always_comb
    begin
        port_next       = port_reg;
        mode_next       = mode_reg;
        tick_count_next = tick_count_reg;
        if (ctl.tick)
        begin
            tick_count_next = do_step ? '0 : tick_inc;
            if (do_step)
            begin
                port_next[5:2] = lamps_step;
            end
        end
        if (ctl.apply)
        begin
            unique case (ctl.word)
                WORD_LED0_OFF: port_next[0] = 1'b0;
                WORD_LED0_ON:  port_next[0] = 1'b1;
                WORD_LED1_OFF: port_next[1] = 1'b0;
                WORD_LED1_ON:  port_next[1] = 1'b1;
                WORD_LEFT:     mode_next    = MODE_LEFT;
                WORD_RIGHT:    mode_next    = MODE_RIGHT;
                WORD_FLASHING: mode_next    = MODE_FLASHING;
                WORD_TIME_OUT: mode_next    = MODE_PAUSE;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= TICK_PERIOD_RESET;
            tick_count_reg <= TICK_COUNT_RESET;
            port_reg       <= '1;
            mode_reg       <= MODE_PAUSE;
        end
        else
        begin
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
            tick_count_reg <= tick_count_next;
            port_reg       <= port_next;
            mode_reg       <= mode_next;
        end
    end

endmodule

>>> hw/rtl/serial_command_led_controller.sv
// Top level of the serial command LED controller.
// Depends on sclc_pkg, sclc_if, sclc_cmd_buf and sclc_lamps.
//
// Usage:
//   cmd_in  carries one request per handshake: a serial byte (command 0)
//           or a timer tick (command 1). Bytes other than '#' or NUL are
//           gathered into a command; '#' or NUL ends it and the command is
//           matched against the eight fixed words.
//   led_out returns exactly one result per request: both single LEDs, the
//           four running lamps and the mode after that request, plus the
//           code of the word recognized by a terminator (0 otherwise).
//   cfg_we / cfg_wdata write tick_period (ticks between lamp steps); write
//           it only while no request is in flight.
// Path: an accepted request is held in the input register, and its result is
//   registered in the result register, from which led_out takes it.
// Throughput: one request per cycle while led_out keeps taking results;
//   every request takes a single pass through the matcher and lamp logic
//   between the input register and the result register.
// Reset: both LEDs and all lamps lit, pause mode, tick period 500, tick
//   count 1, empty command, no request or result held.
// Stall: a result not taken holds in the output register; the input
//   register still fills behind it, then ready drops until led_out drains.
module serial_command_led_controller import sclc_pkg::*;
#(
    parameter int BUFFER_CHARS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    sclc_in_if.sink             cmd_in,
    sclc_out_if.source          led_out,
    input  logic                cfg_we,
    input  logic [PERIOD_W-1:0] cfg_wdata
);

    // Input register
    logic           s1_valid_reg;
    sclc_item_t     s1_item_reg;
    // Result register
    logic           out_valid_reg;
    sclc_result_t   out_data_reg;
    sclc_result_t   out_data_next;

    logic           out_free;
    logic           fire;
    logic           is_term;
    logic [3:0]     matched_word;
    logic [5:0]     port_next;
    light_mode_t    mode_next;
    sclc_lamp_ctl_t lamp_ctl;

    // The result slot takes a new value when empty or being drained
    assign out_free = !out_valid_reg || led_out.ready;
    assign fire     = s1_valid_reg && out_free;
    assign cmd_in.ready = !s1_valid_reg || out_free;

    assign is_term = (s1_item_reg.byte_value == TERM_CHAR) ||
                     (s1_item_reg.byte_value == NUL_CHAR);

    assign lamp_ctl.tick  = fire && (s1_item_reg.command == CMD_TICK);
    assign lamp_ctl.apply = fire && (s1_item_reg.command == CMD_BYTE) && is_term;
    assign lamp_ctl.word  = matched_word;

    sclc_cmd_buf #(
        .BUFFER_CHARS (BUFFER_CHARS)
    ) u_cmd_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (fire && (s1_item_reg.command == CMD_BYTE) && !is_term),
        .term         (lamp_ctl.apply),
        .byte_value   (s1_item_reg.byte_value),
        .matched_word (matched_word)
    );

    sclc_lamps u_lamps (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctl       (lamp_ctl),
        .port_next (port_next),
        .mode_next (mode_next)
    );

    // Report the state as it stands after this request
    always_comb
    begin
        out_data_next.led_zero     = port_next[0];
        out_data_next.led_one      = port_next[1];
        out_data_next.run_lights   = port_next[5:2];
        out_data_next.light_mode   = mode_next;
        out_data_next.matched_word = lamp_ctl.apply ? matched_word : WORD_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_in.ready)
            begin
                s1_valid_reg <= cmd_in.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_in.valid && cmd_in.ready)
        begin
            s1_item_reg <= cmd_in.data;
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign led_out.valid = out_valid_reg;
    assign led_out.data  = out_data_reg;

endmodule

>>> hw/rtl/sclc_checker.sv
// Port-level checks for the serial command LED controller, bound to the top.
// Depends on sclc_pkg for word codes and modes.
module sclc_checker import sclc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         out_valid,
    input logic         out_ready,
    input sclc_result_t out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    a_led0_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.matched_word == WORD_LED0_OFF |-> !out_data.led_zero)
        else $error("Led0:OFF did not clear LED zero");

    a_led1_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.matched_word == WORD_LED1_ON |-> out_data.led_one)
        else $error("Led1:ON did not light LED one");

    a_left_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.matched_word == WORD_LEFT |->
            out_data.light_mode == MODE_LEFT)
        else $error("left did not select left mode");

    a_time_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.matched_word == WORD_TIME_OUT |->
            out_data.light_mode == MODE_PAUSE)
        else $error("Time out did not select pause");

endmodule

bind serial_command_led_controller sclc_checker u_sclc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (led_out.valid),
    .out_ready (led_out.ready),
    .out_data  (led_out.data)
);

>>> sim/tb_top.sv
// Self-checking testbench for serial_command_led_controller.
// Depends on sclc_pkg, the sclc_in_if/sclc_out_if interfaces and the RTL top.
// Predicts every result in a small scoreboard class; plain tasks drive requests.
module tb_top import sclc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CMD_CHARS = 8;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [PERIOD_W-1:0] cfg_wdata;

    sclc_in_if  cmd_if ();
    sclc_out_if led_if ();

    // Idle chances in percent, changed between phases
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned sent_count;
    int unsigned phase_count;

    serial_command_led_controller #(
        .BUFFER_CHARS (CMD_CHARS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (cmd_if),
        .led_out   (led_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Text of each fixed command word, looked up by its result code
    function automatic string command_word(logic [3:0] code);
        case (code)
            WORD_LED0_OFF: return "Led0:OFF";
            WORD_LED0_ON:  return "Led0:ON";
            WORD_LED1_OFF: return "Led1:OFF";
            WORD_LED1_ON:  return "Led1:ON";
            WORD_LEFT:     return "left";
            WORD_RIGHT:    return "right";
            WORD_FLASHING: return "flashing";
            WORD_TIME_OUT: return "Time out";
            default:       return "";
        endcase
    endfunction

    // Predicts the controller's state per request and checks results in order.
    class cmd_scoreboard;
        logic [7:0]          chars [CMD_CHARS];
        int unsigned         nchars;
        bit                  overflow;
        light_mode_t         mode;
        logic                led0;
        logic                led1;
        logic [3:0]          lamps;
        logic [PERIOD_W-1:0] tick_cnt;
        logic [PERIOD_W-1:0] tick_period;
        sclc_result_t        expected_q [$];
        int unsigned         mismatches;
        int unsigned         requests;
        int unsigned         words_hit;
        int unsigned         lamp_steps;
        int unsigned         overflows;

        function new();
            tick_period = TICK_PERIOD_RESET;
            tick_cnt    = TICK_COUNT_RESET;
            nchars      = 0;
            overflow    = 1'b0;
            mode        = MODE_PAUSE;
            led0        = 1'b1;
            led1        = 1'b1;
            lamps       = 4'hF;
            mismatches  = 0;
            requests    = 0;
            words_hit   = 0;
            lamp_steps  = 0;
            overflows   = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function logic [3:0] find_word();
            string txt;
            bit    same;
            if (overflow || nchars == 0)
                return WORD_NONE;
            for (int code = int'(WORD_LED0_OFF); code <= int'(WORD_TIME_OUT); code++)
            begin
                txt = command_word(4'(code));
                if (txt.len() == nchars)
                begin
                    same = 1'b1;
                    for (int k = 0; k < nchars; k++)
                        if (txt[k] != chars[k])
                            same = 1'b0;
                    if (same)
                        return 4'(code);
                end
            end
            return WORD_NONE;
        endfunction

        function void apply_word(logic [3:0] code);
            case (code)
                WORD_LED0_OFF: led0 = 1'b0;
                WORD_LED0_ON:  led0 = 1'b1;
                WORD_LED1_OFF: led1 = 1'b0;
                WORD_LED1_ON:  led1 = 1'b1;
                WORD_LEFT:     mode = MODE_LEFT;
                WORD_RIGHT:    mode = MODE_RIGHT;
                WORD_FLASHING: mode = MODE_FLASHING;
                WORD_TIME_OUT: mode = MODE_PAUSE;
                default: ;
            endcase
        endfunction

        // Patterns other than none, all or one lamp hold in left and right mode
        function void step_lamps();
            case (mode)
                MODE_LEFT:
                    case (lamps)
                        4'h0, 4'hF: lamps = 4'h1;
                        4'h1:       lamps = 4'h2;
                        4'h2:       lamps = 4'h4;
                        4'h4:       lamps = 4'h8;
                        4'h8:       lamps = 4'h1;
                        default: ;
                    endcase
                MODE_RIGHT:
                    case (lamps)
                        4'h0, 4'hF: lamps = 4'h8;
                        4'h1:       lamps = 4'h8;
                        4'h2:       lamps = 4'h1;
                        4'h4:       lamps = 4'h2;
                        4'h8:       lamps = 4'h4;
                        default: ;
                    endcase
                MODE_FLASHING: lamps = ~lamps;
                default: ;
            endcase
        endfunction

        function void note_request(sclc_item_t req);
            sclc_result_t want;
            logic [3:0]   hit;
            hit = WORD_NONE;
            requests++;
            if (req.command == CMD_TICK)
            begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= tick_period)
                begin
                    step_lamps();
                    tick_cnt = '0;
                    lamp_steps++;
                end
            end
            else if (req.byte_value != TERM_CHAR && req.byte_value != NUL_CHAR)
            begin
                if (nchars < CMD_CHARS)
                begin
                    chars[nchars] = req.byte_value;
                    nchars++;
                end
                else
                begin
                    if (!overflow)
                        overflows++;
                    overflow = 1'b1;
                end
            end
            else
            begin
                hit = find_word();
                apply_word(hit);
                if (hit != WORD_NONE)
                    words_hit++;
                nchars   = 0;
                overflow = 1'b0;
            end
            want.led_zero     = led0;
            want.led_one      = led1;
            want.run_lights   = lamps;
            want.light_mode   = mode;
            want.matched_word = hit;
            expected_q.push_back(want);
        endfunction

        function void check_result(sclc_result_t got);
            sclc_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result %h arrived with no request outstanding", got);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.led_zero !== want.led_zero)
            begin
                $error("led_zero: expected %0d, got %0d", want.led_zero, got.led_zero);
                mismatches++;
            end
            if (got.led_one !== want.led_one)
            begin
                $error("led_one: expected %0d, got %0d", want.led_one, got.led_one);
                mismatches++;
            end
            if (got.run_lights !== want.run_lights)
            begin
                $error("run_lights: expected %h, got %h", want.run_lights, got.run_lights);
                mismatches++;
            end
            if (got.light_mode !== want.light_mode)
            begin
                $error("light_mode: expected %0d, got %0d", want.light_mode, got.light_mode);
                mismatches++;
            end
            if (got.matched_word !== want.matched_word)
            begin
                $error("matched_word: expected %0d, got %0d",
                       want.matched_word, got.matched_word);
                mismatches++;
            end
        endfunction
    endclass

    cmd_scoreboard sb;

    // Free-running 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case a handshake hangs; far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Result side: check every result taken at an edge, then pick the next
    // ready at random so stalls land on every phase of the output register.
    initial
    begin
        led_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && led_if.valid && led_if.ready)
                sb.check_result(led_if.data);
            led_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Drive one request and hold it until the block takes it. Valid stays
    // high on return so back-to-back requests need no second assignment.
    task automatic send_req(input logic kind, input logic [7:0] value);
        sclc_item_t req;
        req.command    = kind;
        req.byte_value = value;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= req;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        sb.note_request(req);
        sent_count++;
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n)
            send_req(CMD_TICK, 8'($urandom_range(255)));
    endtask

    task automatic send_term();
        send_req(CMD_BYTE, $urandom_range(1) ? TERM_CHAR : NUL_CHAR);
    endtask

    task automatic send_command(input string txt, input logic [7:0] term);
        for (int i = 0; i < txt.len(); i++)
            send_req(CMD_BYTE, txt[i]);
        send_req(CMD_BYTE, term);
    endtask

    // Any character that gets buffered: neither terminator
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255, 1));
        while (c == TERM_CHAR);
        return c;
    endfunction

    // Mostly a real word; sometimes corrupt, lengthen or cut it
    task automatic random_command();
        logic [7:0] msg [$];
        string      txt;
        int unsigned pick;
        txt = command_word(4'($urandom_range(WORD_TIME_OUT, WORD_LED0_OFF)));
        for (int i = 0; i < txt.len(); i++)
            msg.push_back(txt[i]);
        pick = $urandom_range(99);
        if (pick < 12)
            msg[$urandom_range(msg.size() - 1)] = plain_char();
        else if (pick < 22)
            repeat ($urandom_range(4, 1))
                msg.push_back(plain_char());
        else if (pick < 30)
            void'(msg.pop_back());
        foreach (msg[i])
            send_req(CMD_BYTE, msg[i]);
        send_term();
    endtask

    // Raw bytes of any value, terminators included
    task automatic random_noise();
        repeat ($urandom_range(10, 1))
            send_req(CMD_BYTE, 8'($urandom_range(255)));
        if ($urandom_range(1))
            send_term();
    endtask

    // Drop valid and wait for every outstanding result; one result per request
    // means the block holds nothing once the expectation queue is empty.
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] period);
        cfg_we    <= 1'b1;
        cfg_wdata <= period;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.tick_period = period;
    endtask

    // One random phase: drain, reprogram the period, then a mix of commands,
    // tick bursts and noise until the request quota is spent.
    task automatic run_phase(input logic [PERIOD_W-1:0] period,
                             input int unsigned s_idle, input int unsigned r_idle,
                             input int unsigned quota);
        int unsigned start;
        int unsigned pick;
        drain();
        write_period(period);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        phase_count++;
        start = sent_count;
        while (sent_count - start < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                random_command();
            else if (pick < 80)
                send_ticks($urandom_range(6, 1));
            else
                random_noise();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cmd_if.valid  = 1'b0;
        cmd_if.data   = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        send_idle_pct = 35;
        recv_idle_pct = 77;
        sent_count    = 0;
        phase_count   = 0;
        sb = new();

        // Hold reset, then release at an edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset period: every word, both terminators,
        // an empty command, near misses and commands too long for the buffer.
        send_command("Led0:OFF", TERM_CHAR);
        send_command("Led1:OFF", NUL_CHAR);
        send_command("Led0:ON", TERM_CHAR);
        send_command("Led1:ON", NUL_CHAR);
        send_command("flashing", TERM_CHAR);
        send_command("right", TERM_CHAR);
        send_command("LEFT", TERM_CHAR);
        send_command("", TERM_CHAR);
        send_command("", NUL_CHAR);
        send_command("Led1:OFFx", TERM_CHAR);
        send_command("flashing!!", NUL_CHAR);
        send_req(CMD_BYTE, 8'hFF);
        send_req(CMD_BYTE, 8'h80);
        send_req(CMD_BYTE, 8'h7F);
        send_term();
        send_ticks(3);
        send_command("Time out", TERM_CHAR);
        // Tick count starts at one, so the first step of the reset period
        // lands on tick 499; left mode makes it visible on the lamps.
        send_command("left", TERM_CHAR);
        send_ticks(int'(TICK_PERIOD_RESET - TICK_COUNT_RESET));

        // Random part: receiver-heavy idling, then sender-heavy, then none
        run_phase(16'd1, 35, 77, 185);
        run_phase(16'd3, 35, 77, 185);
        run_phase(16'd0, 77, 35, 185);
        run_phase(16'hFFFF, 77, 35, 185);
        run_phase(16'd2, 0, 0, 185);
        run_phase(16'd7, 0, 0, 185);

        // Let the last results out, then watch on for strays
        drain();
        repeat (4) @(posedge clk);

        $display("Run covered %0d requests over %0d tick periods after reset.",
                 sb.requests, phase_count + 1);
        $display("Words recognized: %0d, lamp steps: %0d, over-long commands: %0d.",
                 sb.words_hit, sb.lamp_steps, sb.overflows);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
